>>> sv/utfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfs_pkg
// Shared types, constants and the single-byte character map of the
// UTF-8 filename sanitizer.
// ----------------------------------------------------------------------------
package utfs_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned MAX_RES  = 4;
    localparam int unsigned CNT_W    = 3;

    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 10'd64;

    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CH_CTRL_MAX = 8'h1f;
    localparam logic [BYTE_W-1:0] CH_CONT_LO  = 8'h80;
    localparam logic [BYTE_W-1:0] CH_LEAD2    = 8'hc0;
    localparam logic [BYTE_W-1:0] CH_LEAD3    = 8'he0;
    localparam logic [BYTE_W-1:0] CH_LEAD4    = 8'hf0;
    localparam logic [BYTE_W-1:0] CH_DASH     = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5c;
    localparam logic [BYTE_W-1:0] CH_SLASH    = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3a;
    localparam logic [BYTE_W-1:0] CH_STAR     = 8'h2a;
    localparam logic [BYTE_W-1:0] CH_QUEST    = 8'h3f;
    localparam logic [BYTE_W-1:0] CH_DQUOTE   = 8'h22;
    localparam logic [BYTE_W-1:0] CH_LT       = 8'h3c;
    localparam logic [BYTE_W-1:0] CH_GT       = 8'h3e;
    localparam logic [BYTE_W-1:0] CH_PIPE     = 8'h7c;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;

    typedef struct packed {
        logic [CNT_W-1:0]                cnt;
        logic [MAX_RES-1:0][BYTE_W-1:0]  data;
        logic [MAX_RES-1:0]              last;
    } push_t;

    function automatic logic [BYTE_W-1:0] map_single(input logic [BYTE_W-1:0] c);
        logic bad;
        bad = (c == CH_BSLASH) || (c == CH_SLASH) || (c == CH_COLON) ||
              (c == CH_STAR) || (c == CH_QUEST) || (c == CH_DQUOTE) ||
              (c == CH_LT) || (c == CH_GT) || (c == CH_PIPE) ||
              (c == CH_SPACE) || ((c != CH_NUL) && (c <= CH_CTRL_MAX));
        return bad ? CH_DASH : c;
    endfunction

endpackage

>>> sv/utfs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfs_core
// Per-name decode state: sequence tracking, fit check, character map.
// Produces up to four result bytes per accepted input byte.
// ----------------------------------------------------------------------------
module utfs_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [utfs_pkg::LEN_W-1:0]    cfg_data,
    input  logic                          in_fire,
    input  logic [utfs_pkg::BYTE_W-1:0]   in_byte,
    output utfs_pkg::push_t               push
);

    logic [utfs_pkg::LEN_W-1:0]   max_len_reg;
    logic [utfs_pkg::LEN_W-1:0]   written_reg, written_next;
    logic [2:0]                   seq_len_reg, seq_len_next;
    logic [1:0]                   held_cnt_reg, held_cnt_next;
    logic                         halted_reg, halted_next;
    logic [2:0][utfs_pkg::BYTE_W-1:0] held_reg;
    logic                         held_we;
    logic [1:0]                   held_idx;
    logic [2:0]                   lead_len;
    logic [2:0]                   fit_len;
    logic                         fits;
    logic [utfs_pkg::LEN_W+1:0]   need;
    utfs_pkg::push_t              res;

    always_comb
    begin
        if (in_byte >= utfs_pkg::CH_LEAD4)
            lead_len = 3'd4;
        else if (in_byte >= utfs_pkg::CH_LEAD3)
            lead_len = 3'd3;
        else
            lead_len = 3'd2;
        fit_len = (in_byte < utfs_pkg::CH_CONT_LO) ? 3'd1 : lead_len;
        need = (utfs_pkg::LEN_W+2)'(written_reg) + (utfs_pkg::LEN_W+2)'(fit_len)
             + (utfs_pkg::LEN_W+2)'(1);
        fits = (max_len_reg != '0) && (need <= (utfs_pkg::LEN_W+2)'(max_len_reg));
    end

    always_comb
    begin
        written_next  = written_reg;
        seq_len_next  = seq_len_reg;
        held_cnt_next = held_cnt_reg;
        halted_next   = halted_reg;
        held_we       = 1'b0;
        held_idx      = 2'd0;
        res.cnt       = '0;
        res.last      = '0;
        for (int i = 0; i < 3; i++)
        begin
            res.data[i] = (2'(i) < held_cnt_reg) ? held_reg[i] : in_byte;
        end
        res.data[3] = in_byte;
        if (in_byte == utfs_pkg::CH_NUL)
        begin
            if (max_len_reg != '0)
            begin
                res.cnt     = utfs_pkg::CNT_W'(1);
                res.data[0] = utfs_pkg::CH_NUL;
                res.last[0] = 1'b1;
            end
            written_next  = '0;
            seq_len_next  = '0;
            held_cnt_next = '0;
            halted_next   = 1'b0;
        end
        else if (halted_reg || max_len_reg == '0)
        begin
            // drop
        end
        else if (seq_len_reg != '0)
        begin
            if (in_byte[7:6] != 2'b10)
            begin
                halted_next   = 1'b1;
                seq_len_next  = '0;
                held_cnt_next = '0;
            end
            else if (3'(held_cnt_reg) + 3'd1 < seq_len_reg)
            begin
                held_we       = 1'b1;
                held_idx      = held_cnt_reg;
                held_cnt_next = held_cnt_reg + 2'd1;
            end
            else
            begin
                res.cnt       = 3'(held_cnt_reg) + 3'd1;
                written_next  = written_reg + utfs_pkg::LEN_W'(res.cnt);
                seq_len_next  = '0;
                held_cnt_next = '0;
            end
        end
        else if (in_byte < utfs_pkg::CH_CONT_LO)
        begin
            if (!fits)
            begin
                halted_next = 1'b1;
            end
            else
            begin
                res.cnt      = utfs_pkg::CNT_W'(1);
                res.data[0]  = utfs_pkg::map_single(in_byte);
                written_next = written_reg + utfs_pkg::LEN_W'(1);
            end
        end
        else if (in_byte < utfs_pkg::CH_LEAD2)
        begin
            halted_next = 1'b1;
        end
        else if (!fits)
        begin
            halted_next = 1'b1;
        end
        else
        begin
            held_we       = 1'b1;
            held_idx      = 2'd0;
            held_cnt_next = 2'd1;
            seq_len_next  = lead_len;
        end
        push     = res;
        push.cnt = in_fire ? res.cnt : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg  <= utfs_pkg::MAX_LEN_RESET;
            written_reg  <= '0;
            seq_len_reg  <= '0;
            held_cnt_reg <= '0;
            halted_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_data;
            if (in_fire)
            begin
                written_reg  <= written_next;
                seq_len_reg  <= seq_len_next;
                held_cnt_reg <= held_cnt_next;
                halted_reg   <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && held_we)
            held_reg[held_idx] <= in_byte;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg == '0) |-> (held_cnt_reg == '0))
        else $error("held bytes without open sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_len_reg != '0) |-> (seq_len_reg >= 3'd2 && 3'(held_cnt_reg) < seq_len_reg
                                 && held_cnt_reg != '0))
        else $error("held count out of range for open sequence");

    assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> (seq_len_reg == '0))
        else $error("sequence open while halted");

endmodule

>>> sv/utfs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfs_fifo
// Result queue: takes up to four requests per cycle, delivers one per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module utfs_fifo
#(
    parameter int unsigned DEPTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  utfs_pkg::push_t               push,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [utfs_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW:0] DEPTH_W = (PW+1)'(DEPTH);
    localparam logic [CW-1:0] ROOM_MAX = CW'(DEPTH - utfs_pkg::MAX_RES);

    logic [utfs_pkg::BYTE_W:0]       mem [DEPTH];
    logic [PW-1:0]                   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [utfs_pkg::MAX_RES:0][PW-1:0] widx;
    logic [PW:0]                     sum;
    logic [PW:0]                     rsum;
    logic                            pop;

    always_comb
    begin
        for (int k = 0; k <= utfs_pkg::MAX_RES; k++)
        begin
            sum = (PW+1)'(wr_ptr_reg) + (PW+1)'(k);
            if (sum >= DEPTH_W)
                sum = sum - DEPTH_W;
            widx[k] = sum[PW-1:0];
        end
        wr_ptr_next = widx[push.cnt];
        pop  = out_valid && !out_stall;
        rsum = (PW+1)'(rd_ptr_reg) + (PW+1)'(pop);
        if (rsum >= DEPTH_W)
            rsum = rsum - DEPTH_W;
        rd_ptr_next = rsum[PW-1:0];
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    assign room      = (count_reg <= ROOM_MAX);
    assign out_valid = (count_reg != '0);
    assign out_byte  = mem[rd_ptr_reg][utfs_pkg::BYTE_W-1:0];
    assign last      = mem[rd_ptr_reg][utfs_pkg::BYTE_W];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < utfs_pkg::MAX_RES; k++)
        begin
            if (utfs_pkg::CNT_W'(k) < push.cnt)
                mem[widx[k]] <= {push.last[k], push.data[k]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != '0) |-> room)
        else $error("request written without room");

endmodule

>>> sv/utf8_safe_filename_sanitizer.sv
`timescale 1ns / 1ps
// Result bytes of an accepted byte are registered in the result queue before out_byte.
// Throughput: one input byte per cycle; input stalls while the result queue
// has fewer than four free entries (queue depth DEPTH).
// Reset: rst_n clears name state, empties the queue, max_len returns to 64.
// ----------------------------------------------------------------------------
// utf8_safe_filename_sanitizer
// Streams a zero-terminated name and emits a sanitized copy holding only
// complete UTF-8 characters within the configured buffer size.
// ----------------------------------------------------------------------------
module utf8_safe_filename_sanitizer
#(
    parameter int unsigned DEPTH = 8
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [utfs_pkg::LEN_W-1:0]    cfg_max_len,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [utfs_pkg::BYTE_W-1:0]   in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [utfs_pkg::BYTE_W-1:0]   out_byte,
    output logic                          last
);

    utfs_pkg::push_t push;
    logic            room;
    logic            in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = !room;
    assign in_fire   = in_valid && room;

    utfs_core u_core
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_max_len),
        .in_fire  (in_fire),
        .in_byte  (in_byte),
        .push     (push)
    );

    utfs_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last)
    );

endmodule
